// ===== hw/rtl/dtoi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtoi_pkg: shared types and constants for the decimal text converter
// Status codes, target type codes and the parse state record.
// ----------------------------------------------------------------------------
package dtoi_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned STAT_W  = 2;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_I8  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_U8  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_I32 = 3'd2;
   localparam logic [MODE_W-1:0] MODE_U32 = 3'd3;
   localparam logic [MODE_W-1:0] MODE_I64 = 3'd4;
   localparam logic [MODE_W-1:0] MODE_U64 = 3'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // accumulated parse state of one text
   typedef struct packed {
      logic                 is_negative;
      logic [VALUE_W-1:0]   magnitude;
      logic                 overflowed;
      logic                 saw_digit;
      logic                 bad_char;
      logic                 terminated;
      logic [COUNT_W-1:0]   byte_count;
      logic [MODE_W-1:0]    target_type;
      logic                 minus_rejected;
   } parse_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dtoi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtoi_if: valid/ready channels of the decimal text converter
// Byte channel in, result channel out.
// ----------------------------------------------------------------------------
interface dtoi_req_if;
   import dtoi_pkg::*;
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   char_byte;
   logic                no_byte;
   logic                last_byte;
   logic [MODE_W-1:0]   mode;

   modport source (output valid, output char_byte, output no_byte, output last_byte,
                   output mode, input ready);
   modport sink   (input valid, input char_byte, input no_byte, input last_byte,
                   input mode, output ready);
endinterface

interface dtoi_rsp_if;
   import dtoi_pkg::*;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value_bits;
   logic [STAT_W-1:0]   status;

   modport source (output valid, output value_bits, output status, input ready);
   modport sink   (input valid, input value_bits, input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/decimal_text_to_integer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_text_to_integer: ASCII decimal text to binary integer
// Parses a byte stream into i8/u8/i32/u32/i64/u64 with range checking.
// ----------------------------------------------------------------------------
//
//  channel    dir  word contents                              handshake
//  req_chan   in   char_byte, no_byte, last_byte, mode        valid/ready
//  rsp_chan   out  value_bits, status                         valid/ready
//
//  One word per cycle sustained, except that a closing word waits while the
//  snapshot stage is full. Each byte costs one shift-add-compare on the 64-bit
//  magnitude in the parse stage. The last word of a text passes the input
//  register, snapshot register and result register on the way to its result.
//  Reset is synchronous, active high; it clears valids and parse state.
//  A stalled result holds the snapshot stage and any closing word behind it;
//  bytes that do not close a text keep flowing while the result waits.
//
module decimal_text_to_integer
   import dtoi_pkg::*;
#(
   parameter int unsigned MAX_TEXT_BYTES = 63
) (
   input  logic         clock,
   input  logic         reset,
   dtoi_req_if.sink     req_chan,
   dtoi_rsp_if.source   rsp_chan
);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS
   } phase_type;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;

   localparam logic [VALUE_W-1:0] I64_NEG_LIM = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] I32_POS_LIM = 64'd2147483647;
   localparam logic [VALUE_W-1:0] I32_NEG_LIM = 64'd2147483648;
   localparam logic [VALUE_W-1:0] U32_LIM     = 64'd4294967295;
   localparam logic [VALUE_W-1:0] I8_POS_LIM  = 64'd127;
   localparam logic [VALUE_W-1:0] I8_NEG_LIM  = 64'd128;
   localparam logic [VALUE_W-1:0] U8_LIM      = 64'd255;

   localparam logic [COUNT_W-1:0] TEXT_LIMIT = COUNT_W'(MAX_TEXT_BYTES);

   // ---------------- input register ----------------
   logic                in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]   in_char_ff;
   logic                in_none_ff;
   logic                in_last_ff;
   logic [MODE_W-1:0]   in_mode_ff;

   // ---------------- parse state ----------------
   phase_type           phase_ff, phase_in;
   parse_type           st_ff, st_in;
   logic                first_ff, first_in;

   // ---------------- snapshot of a closed text ----------------
   logic                snap_valid_ff, snap_valid_in;
   parse_type           snap_ff, snap_in;

   // ---------------- result register ----------------
   logic                out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]  out_value_ff, out_value_in;
   logic [STAT_W-1:0]   out_status_ff, out_status_in;

   // stage flow control
   logic out_free, snap_move, snap_free, in_go, in_free, req_take;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign snap_move = snap_valid_ff && out_free;
   assign snap_free = !snap_valid_ff || out_free;
   // only a closing word needs room in the snapshot stage
   assign in_go     = in_valid_ff && (!in_last_ff || snap_free);
   assign in_free   = !in_valid_ff || in_go;
   assign req_take  = req_chan.valid && in_free;

   assign req_chan.ready = in_free;

   // ---------------- per-byte parse step ----------------
   parse_type           nx;
   phase_type           nx_phase;
   logic [VALUE_W+3:0]  prod;
   logic                is_digit, is_ws;

   always_comb begin
      nx       = st_ff;
      nx_phase = phase_ff;
      if (first_ff) begin
         nx.target_type = in_mode_ff;
      end
      is_digit = (in_char_ff >= CHAR_0) && (in_char_ff <= CHAR_9);
      is_ws    = (in_char_ff == CHAR_SPACE) ||
                 ((in_char_ff >= CHAR_TAB) && (in_char_ff <= CHAR_CR));
      // magnitude * 10 + digit, with four guard bits for overflow
      prod = ({4'b0, st_ff.magnitude} << 3) + ({4'b0, st_ff.magnitude} << 1) +
             (VALUE_W+4)'(in_char_ff[3:0]);
      if (!in_none_ff) begin
         if (st_ff.byte_count != COUNT_MAX) begin
            nx.byte_count = st_ff.byte_count + COUNT_W'(1);
         end
         if (!st_ff.terminated && !st_ff.bad_char) begin
            priority if (in_char_ff == CHAR_NUL) begin
               nx.terminated = 1'b1;
            end else if (is_digit) begin
               if (st_ff.overflowed || (prod[VALUE_W+3:VALUE_W] != 4'd0)) begin
                  nx.overflowed = 1'b1;
                  nx.magnitude  = '1;
               end else begin
                  nx.magnitude  = prod[VALUE_W-1:0];
               end
               nx.saw_digit = 1'b1;
               nx_phase     = PH_DIGITS;
            end else if (phase_ff == PH_SPACE && is_ws) begin
               nx_phase = PH_SPACE;
            end else if (phase_ff == PH_SPACE &&
                         (in_char_ff == CHAR_PLUS || in_char_ff == CHAR_MINUS)) begin
               if (in_char_ff == CHAR_MINUS) begin
                  nx.is_negative = 1'b1;
                  if (nx.target_type == MODE_U64) begin
                     nx.minus_rejected = 1'b1;
                  end
               end
               nx_phase = PH_SIGN;
            end else begin
               nx.bad_char = 1'b1;
            end
         end
      end
   end

   // ---------------- finish: status and value from the snapshot ----------------
   logic                bad_syntax, outside_i64, fits;
   logic [VALUE_W-1:0]  pattern;

   always_comb begin
      bad_syntax  = !snap_ff.saw_digit || snap_ff.bad_char;
      outside_i64 = snap_ff.overflowed ||
                    (snap_ff.is_negative ? (snap_ff.magnitude > I64_NEG_LIM)
                                         : snap_ff.magnitude[VALUE_W-1]);
      pattern     = snap_ff.is_negative ? (VALUE_W'(0) - snap_ff.magnitude)
                                        : snap_ff.magnitude;
      unique case (snap_ff.target_type)
         MODE_I8:  fits = snap_ff.is_negative ? (snap_ff.magnitude <= I8_NEG_LIM)
                                              : (snap_ff.magnitude <= I8_POS_LIM);
         MODE_U8:  fits = snap_ff.is_negative ? (snap_ff.magnitude == '0)
                                              : (snap_ff.magnitude <= U8_LIM);
         MODE_I32: fits = snap_ff.is_negative ? (snap_ff.magnitude <= I32_NEG_LIM)
                                              : (snap_ff.magnitude <= I32_POS_LIM);
         default:  fits = snap_ff.is_negative ? (snap_ff.magnitude == '0)
                                              : (snap_ff.magnitude <= U32_LIM);
      endcase

      out_value_in  = '0;
      out_status_in = STATUS_OK;
      priority if (snap_ff.byte_count > TEXT_LIMIT || snap_ff.target_type > MODE_U64) begin
         out_status_in = STATUS_INVALID;
      end else if (snap_ff.target_type == MODE_U64) begin
         // u64: a rejected minus or a real overflow wins over syntax
         priority if (snap_ff.minus_rejected || (snap_ff.saw_digit && snap_ff.overflowed))
         begin
            out_status_in = STATUS_RANGE;
         end else if (bad_syntax) begin
            out_status_in = STATUS_INVALID;
         end else begin
            out_value_in = snap_ff.magnitude;
         end
      end else if (bad_syntax) begin
         out_status_in = STATUS_INVALID;
      end else if (snap_ff.target_type == MODE_I64) begin
         if (outside_i64) begin
            out_status_in = STATUS_RANGE;
         end else begin
            out_value_in = pattern;
         end
      end else if (outside_i64) begin
         // narrow targets: beyond i64 counts as a bad literal
         out_status_in = STATUS_INVALID;
      end else if (!fits) begin
         out_status_in = STATUS_RANGE;
      end else begin
         out_value_in = pattern;
      end
   end

   // ---------------- next-state selection ----------------
   always_comb begin
      in_valid_in   = in_free ? req_chan.valid : in_valid_ff;
      st_in         = st_ff;
      phase_in      = phase_ff;
      first_in      = first_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_move ? 1'b0 : snap_valid_ff;
      out_valid_in  = out_free ? snap_valid_ff : out_valid_ff;

      if (in_go) begin
         if (in_last_ff) begin
            // close the text, start the next one from a clean state
            snap_in       = nx;
            snap_valid_in = 1'b1;
            st_in         = '0;
            phase_in      = PH_SPACE;
            first_in      = 1'b1;
         end else begin
            st_in    = nx;
            phase_in = nx_phase;
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         st_ff         <= '0;
         phase_ff      <= PH_SPACE;
         first_ff      <= 1'b1;
      end else begin
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
         st_ff         <= st_in;
         phase_ff      <= phase_in;
         first_ff      <= first_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.char_byte;
         in_none_ff <= req_chan.no_byte;
         in_last_ff <= req_chan.last_byte;
         in_mode_ff <= req_chan.mode;
      end
      snap_ff <= snap_in;
      if (out_free && snap_valid_ff) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.value_bits = out_value_ff;
   assign rsp_chan.status     = out_status_ff;

endmodule
`default_nettype wire

// ===== tb/tb_decimal_text_to_integer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_integer: self-checking bench for the decimal text parser
// Streams texts one byte word at a time, predicts each closing result with a
// local parser model, and checks value and status of every result word in
// order. A short table of directed texts runs first, followed by a long
// result-side stall and random texts under three pacing profiles.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_integer;
   import dtoi_pkg::*;

   localparam int TEXT_LIMIT = 63;

   // codes the package leaves unnamed: target types with no meaning
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHR_SPACE = " ";
   localparam logic [CHAR_W-1:0] CHR_PLUS  = "+";
   localparam logic [CHAR_W-1:0] CHR_MINUS = "-";
   localparam logic [CHAR_W-1:0] CHR_ZERO  = "0";
   localparam logic [CHAR_W-1:0] CHR_NINE  = "9";
   localparam logic [CHAR_W-1:0] BLANK_SET [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   localparam logic [7:0]        NO_NUL = 8'hFF;

   // magnitudes on a target or digit-count boundary (random picks add -1/0/+1)
   localparam logic [VALUE_W-1:0] EDGE_SET [8] = '{
      64'd0, 64'd10, 64'd128, 64'd256, 64'h8000_0000, 64'h1_0000_0000,
      64'h8000_0000_0000_0000, 64'd100};

   typedef enum logic [1:0] {SCAN_BLANKS, SCAN_SIGNED, SCAN_DIGITS} scan_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [STAT_W-1:0]  status;
   } result_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [7:0]         zeros;       // '0' bytes sent ahead of the text
      logic [7:0]         nul_at;      // text index replaced by a zero byte
      logic               close_empty; // close with a no-byte word
      logic               known;       // expectation typed into the table
      logic [VALUE_W-1:0] value;
      logic [STAT_W-1:0]  status;
   } drill_row_type;

   logic clock;
   logic reset;

   dtoi_req_if req_chan ();
   dtoi_rsp_if rsp_chan ();

   decimal_text_to_integer #(
      .MAX_TEXT_BYTES (TEXT_LIMIT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // ---------------------------------------------------------------------
   // Parser model state: one text in flight
   // ---------------------------------------------------------------------
   scan_type           scan;
   logic               neg;
   logic [VALUE_W-1:0] mag;
   logic               ovf;
   logic               digit_seen;
   logic               junk;        // a byte broke the syntax
   logic               ended;       // zero byte seen
   logic [COUNT_W-1:0] byte_cnt;
   logic [MODE_W-1:0]  tgt;
   logic               minus_bad;   // '-' seen under u64
   logic               fresh_text;  // next word opens a text

   result_type    results_due[$];
   result_type    due;
   result_type    typed_result;
   logic          typed_pending;
   drill_row_type drill_rows[$];
   string         drill_text[$];
   logic [7:0]    text_bytes[$];

   int           send_idle_pct;
   int           recv_idle_pct;
   logic         long_stall_req;
   int           bytes_sent;
   int           results_seen;
   int           mismatches;
   int           status_tally[4];

   function automatic void clear_scan();
      scan       = SCAN_BLANKS;
      neg        = 1'b0;
      mag        = '0;
      ovf        = 1'b0;
      digit_seen = 1'b0;
      junk       = 1'b0;
      ended      = 1'b0;
      byte_cnt   = '0;
      tgt        = MODE_I8;
      minus_bad  = 1'b0;
      fresh_text = 1'b1;
   endfunction

   // Advance the model by one accepted word; has is set when the word
   // closes a text, and r then holds the expected result.
   function automatic void predict_word(input logic [CHAR_W-1:0] c, input logic nob,
                                        input logic last, input logic [MODE_W-1:0] m,
                                        output logic has, output result_type r);
      logic [VALUE_W-1:0] d;
      logic               syntax_bad;
      logic               beyond_i64;
      logic               fits;
      has = 1'b0;
      r   = '0;
      if (fresh_text) begin
         tgt        = m;
         fresh_text = 1'b0;
      end
      if (!nob) begin
         if (byte_cnt != COUNT_MAX) byte_cnt++;
         if (!(ended || junk)) begin
            if (c == CHR_NUL) begin
               ended = 1'b1;
            end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
               d = VALUE_W'(c - CHR_ZERO);
               // saturate once the next digit would pass 2^64-1
               if (ovf || mag > ('1 - d) / 64'd10) begin
                  ovf = 1'b1;
                  mag = '1;
               end else begin
                  mag = mag * 64'd10 + d;
               end
               digit_seen = 1'b1;
               scan       = SCAN_DIGITS;
            end else if (scan == SCAN_BLANKS &&
                         (c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR))) begin
               // leading blank: skipped
            end else if (scan == SCAN_BLANKS && (c == CHR_PLUS || c == CHR_MINUS)) begin
               if (c == CHR_MINUS) begin
                  neg = 1'b1;
                  if (tgt == MODE_U64) minus_bad = 1'b1;
               end
               scan = SCAN_SIGNED;
            end else begin
               junk = 1'b1;
            end
         end
      end
      if (!last) return;

      has        = 1'b1;
      syntax_bad = !digit_seen || junk;
      beyond_i64 = ovf || (neg ? mag > 64'h8000_0000_0000_0000
                               : mag > 64'h7FFF_FFFF_FFFF_FFFF);
      if (byte_cnt > TEXT_LIMIT || tgt > MODE_U64) begin
         r.status = STATUS_INVALID;
      end else if (tgt == MODE_U64) begin
         // u64 checks range before syntax
         if (minus_bad || (digit_seen && ovf)) r.status = STATUS_RANGE;
         else if (syntax_bad)                  r.status = STATUS_INVALID;
         else                                  r.status = STATUS_OK;
      end else if (syntax_bad) begin
         r.status = STATUS_INVALID;
      end else if (tgt == MODE_I64) begin
         r.status = beyond_i64 ? STATUS_RANGE : STATUS_OK;
      end else if (beyond_i64) begin
         // narrow targets call a value past i64 invalid, not out of range
         r.status = STATUS_INVALID;
      end else begin
         case (tgt)
            MODE_I8:  fits = neg ? mag <= 64'd128 : mag <= 64'd127;
            MODE_U8:  fits = neg ? mag == 64'd0   : mag <= 64'd255;
            MODE_I32: fits = neg ? mag <= 64'h8000_0000 : mag <= 64'h7FFF_FFFF;
            default:  fits = neg ? mag == 64'd0   : mag <= 64'hFFFF_FFFF;
         endcase
         r.status = fits ? STATUS_OK : STATUS_RANGE;
      end
      if (r.status == STATUS_OK) r.value = neg ? 64'd0 - mag : mag;
      clear_scan();
   endfunction

   // ---------------------------------------------------------------------
   // Clock, timeout
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d results still due", $time, results_due.size());
      $display("tb_decimal_text_to_integer failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random ready, plus a long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            stall_left     = 400;
            long_stall_req = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Compare each result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_seen++;
         if (results_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, got value %h status %0d",
                     $time, rsp_chan.value_bits, rsp_chan.status);
         end else begin
            due = results_due.pop_front();
            if (rsp_chan.value_bits !== due.value) begin
               mismatches++;
               $display("%0t: result %0d value expected %h got %h", $time,
                        results_seen, due.value, rsp_chan.value_bits);
            end
            if (rsp_chan.status !== due.status) begin
               mismatches++;
               $display("%0t: result %0d status expected %0d got %0d", $time,
                        results_seen, due.status, rsp_chan.status);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------

   // Offer one word after a random gap, hold it until taken, then predict.
   task automatic push_word(input logic [CHAR_W-1:0] c, input logic nob, input logic last,
                            input logic [MODE_W-1:0] m);
      logic       has;
      result_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_byte <= c;
      req_chan.no_byte   <= nob;
      req_chan.last_byte <= last;
      req_chan.mode      <= m;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_word(c, nob, last, m, has, r);
      if (has) begin
         if (typed_pending) r = typed_result;
         typed_pending = 1'b0;
         results_due.push_back(r);
         status_tally[r.status]++;
      end
      if (!nob) bytes_sent++;
   endtask

   // Send text_bytes as one text. Only the first word carries the real
   // target; later words carry junk in mode, and empty words are sprinkled in.
   task automatic send_text(input logic [MODE_W-1:0] m, input logic close_empty);
      logic first;
      first = 1'b1;
      for (int i = 0; i < text_bytes.size(); i++) begin
         if ($urandom_range(0, 19) == 0) begin
            push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0,
                      first ? m : MODE_W'($urandom_range(0, 7)));
            first = 1'b0;
         end
         push_word(text_bytes[i], 1'b0, !close_empty && i == text_bytes.size() - 1,
                   first ? m : MODE_W'($urandom_range(0, 7)));
         first = 1'b0;
      end
      if (close_empty || text_bytes.size() == 0)
         push_word(8'($urandom_range(0, 255)), 1'b1, 1'b1,
                   first ? m : MODE_W'($urandom_range(0, 7)));
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic add_drill(input logic [MODE_W-1:0] m, input string t, input int zeros,
                            input logic [7:0] nul_at, input logic close_empty,
                            input logic known, input logic [VALUE_W-1:0] v,
                            input logic [STAT_W-1:0] s);
      drill_row_type rw;
      rw.mode        = m;
      rw.zeros       = 8'(zeros);
      rw.nul_at      = nul_at;
      rw.close_empty = close_empty;
      rw.known       = known;
      rw.value       = v;
      rw.status      = s;
      drill_rows.push_back(rw);
      drill_text.push_back(t);
   endtask

   // One random text: mostly well-formed numbers, some near the target limits,
   // some broken by a stray byte, plus noise, long texts and empty texts.
   task automatic send_random_text();
      logic [MODE_W-1:0]  m;
      logic [VALUE_W-1:0] val;
      string              digits;
      int                 kind;
      int                 n;
      m    = ($urandom_range(0, 19) == 0) ? MODE_W'($urandom_range(6, 7))
                                          : MODE_W'($urandom_range(0, 5));
      kind = $urandom_range(0, 99);
      text_bytes.delete();
      if (kind < 72) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_bytes.push_back(BLANK_SET[$urandom_range(0, 5)]);
         case ($urandom_range(0, 3))
            0:       text_bytes.push_back(CHR_MINUS);
            1:       text_bytes.push_back(CHR_PLUS);
            default: ;
         endcase
         case ($urandom_range(0, 5))
            0:       val = VALUE_W'($urandom_range(0, 9));
            1:       val = VALUE_W'($urandom_range(0, 300));
            2, 3:    val = EDGE_SET[$urandom_range(0, 7)] + VALUE_W'($urandom_range(0, 2))
                           - 64'd1;
            default: val = {$urandom, $urandom} >> $urandom_range(0, 63);
         endcase
         digits = $sformatf("%0d", val);
         for (int i = 0; i < digits.len(); i++) text_bytes.push_back(digits[i]);
         // extra digits can push past 2^64-1
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
               text_bytes.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
         if (kind >= 58) begin
            case ($urandom_range(0, 4))
               0:       text_bytes.insert($urandom_range(0, text_bytes.size()), CHR_NUL);
               1:       text_bytes.insert($urandom_range(0, text_bytes.size()), CHR_SPACE);
               2:       text_bytes.insert($urandom_range(0, text_bytes.size()), CHR_MINUS);
               default: text_bytes.insert($urandom_range(0, text_bytes.size()),
                                          8'($urandom_range(0, 255)));
            endcase
         end
      end else if (kind < 92) begin
         repeat ($urandom_range(0, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 97) begin
         // around the length limit
         n = $urandom_range(58, 68);
         if ($urandom_range(0, 1)) begin
            text_bytes.push_back(CHR_MINUS);
            n--;
         end
         repeat (n - 1) text_bytes.push_back(CHR_ZERO);
         text_bytes.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
      end
      send_text(m, $urandom_range(0, 15) == 0);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      drill_row_type rw;
      int            phase_start;
      req_chan.valid     <= 1'b0;
      req_chan.char_byte <= '0;
      req_chan.no_byte   <= 1'b0;
      req_chan.last_byte <= 1'b0;
      req_chan.mode      <= '0;
      reset              <= 1'b1;
      clear_scan();
      typed_pending  = 1'b0;
      long_stall_req = 1'b0;
      send_idle_pct  = 15;
      recv_idle_pct  = 63;
      bytes_sent     = 0;
      results_seen   = 0;
      mismatches     = 0;
      foreach (status_tally[i]) status_tally[i] = 0;

      // directed texts; known = 1 rows carry their own expectation
      add_drill(MODE_I8,  "127",  0, NO_NUL, 1'b0, 1'b1, 64'd127, STATUS_OK);
      add_drill(MODE_I8,  "-128", 0, NO_NUL, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FF80, STATUS_OK);
      add_drill(MODE_I8,  "128",  0, NO_NUL, 1'b0, 1'b1, '0, STATUS_RANGE);
      add_drill(MODE_U8,  "255",  0, NO_NUL, 1'b0, 1'b1, 64'd255, STATUS_OK);
      add_drill(MODE_U8,  "-0",   0, NO_NUL, 1'b0, 1'b1, '0, STATUS_OK);
      add_drill(MODE_U8,  "-1",   0, NO_NUL, 1'b0, 1'b1, '0, STATUS_RANGE);
      add_drill(MODE_I32, "  -2147483648", 0, NO_NUL, 1'b0, 1'b1, 64'hFFFF_FFFF_8000_0000,
                STATUS_OK);
      add_drill(MODE_U32, "4294967296", 0, NO_NUL, 1'b0, 1'b1, '0, STATUS_RANGE);
      add_drill(MODE_I64, "9223372036854775807", 0, NO_NUL, 1'b0, 1'b1,
                64'h7FFF_FFFF_FFFF_FFFF, STATUS_OK);
      add_drill(MODE_I64, "-9223372036854775809", 0, NO_NUL, 1'b0, 1'b1, '0, STATUS_RANGE);
      add_drill(MODE_U64, "18446744073709551615", 0, NO_NUL, 1'b0, 1'b1, '1, STATUS_OK);
      add_drill(MODE_U64, "18446744073709551616", 0, NO_NUL, 1'b0, 1'b1, '0, STATUS_RANGE);
      add_drill(MODE_U64, "-0",   0, NO_NUL, 1'b0, 1'b1, '0, STATUS_RANGE);
      // overflow wins over the trailing byte under u64
      add_drill(MODE_U64, "99999999999999999999x", 0, NO_NUL, 1'b0, 1'b1, '0, STATUS_RANGE);
      add_drill(MODE_I32, "",     0, NO_NUL, 1'b0, 1'b1, '0, STATUS_INVALID);
      add_drill(MODE_I8,  "+",    0, NO_NUL, 1'b0, 1'b1, '0, STATUS_INVALID);
      add_drill(MODE_I8,  "- 5",  0, NO_NUL, 1'b0, 1'b1, '0, STATUS_INVALID);
      add_drill(MODE_I32, "12 ",  0, NO_NUL, 1'b0, 1'b1, '0, STATUS_INVALID);
      add_drill(MODE_I8,  "999999999999999999999", 0, NO_NUL, 1'b0, 1'b1, '0,
                STATUS_INVALID);
      add_drill(MODE_SPARE_LO, "5", 0, NO_NUL, 1'b0, 1'b1, '0, STATUS_INVALID);
      add_drill(MODE_SPARE_HI, "5", 0, NO_NUL, 1'b0, 1'b1, '0, STATUS_INVALID);
      add_drill(MODE_I32, "1",   62, NO_NUL, 1'b0, 1'b1, 64'd1, STATUS_OK);
      add_drill(MODE_I32, "1",   63, NO_NUL, 1'b0, 1'b1, '0, STATUS_INVALID);
      // zero byte ends the text, the rest is only counted
      add_drill(MODE_I8,  "7x9",  0, 8'd1, 1'b0, 1'b0, '0, STATUS_OK);
      add_drill(MODE_I8,  "x5",   0, 8'd0, 1'b0, 1'b0, '0, STATUS_OK);
      add_drill(MODE_I8,  "42",   0, NO_NUL, 1'b1, 1'b0, '0, STATUS_OK);
      add_drill(MODE_U64, "\t\n +00123", 0, NO_NUL, 1'b0, 1'b0, '0, STATUS_OK);
      add_drill(MODE_I64, "12a34", 0, NO_NUL, 1'b0, 1'b0, '0, STATUS_OK);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < drill_rows.size(); i++) begin
         rw = drill_rows[i];
         text_bytes.delete();
         repeat (rw.zeros) text_bytes.push_back(CHR_ZERO);
         for (int k = 0; k < drill_text[i].len(); k++)
            text_bytes.push_back(k == rw.nul_at ? CHR_NUL : drill_text[i][k]);
         typed_pending       = rw.known;
         typed_result.value  = rw.value;
         typed_result.status = rw.status;
         send_text(rw.mode, rw.close_empty);
      end
      wait_for_results();

      // Hold results back for a long stretch while one-digit texts keep
      // coming, so the block backs up into its input.
      long_stall_req = 1'b1;
      repeat (30) begin
         text_bytes.delete();
         text_bytes.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
         send_text(MODE_W'($urandom_range(0, 5)), 1'b0);
      end
      wait_for_results();

      // random texts: sender-light, receiver-light, then full rate
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 15;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 50) send_random_text();
         wait_for_results();
      end

      // leave room for any stray result
      repeat (10) @(posedge clock);

      $display("covered %0d texts in %0d text bytes: %0d ok, %0d invalid, %0d out of range",
               status_tally[STATUS_OK] + status_tally[STATUS_INVALID] +
               status_tally[STATUS_RANGE], bytes_sent, status_tally[STATUS_OK],
               status_tally[STATUS_INVALID], status_tally[STATUS_RANGE]);
      $display("includes a 400-cycle result stall and three pacing profiles, %0d mismatches",
               mismatches);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("tb_decimal_text_to_integer passed");
      end else begin
         $display("tb_decimal_text_to_integer failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dtoi_pkg.sv
hw/rtl/dtoi_if.sv
hw/rtl/decimal_text_to_integer.sv
tb/tb_decimal_text_to_integer.sv
